@@ rtl/salted_string_hash_unit_macros.svh @@
// Assertion macros shared by the salted string hash RTL.
`ifndef SALTED_STRING_HASH_UNIT_MACROS_SVH
`define SALTED_STRING_HASH_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ssh_pkg.sv @@
// Package with the constants, types and hash multiply function of the salted string hash unit.
package ssh_pkg;

    // Hash constants.
    localparam int unsigned HASH_MULT      = 1000003;
    localparam int unsigned FIRST_SHIFT    = 7;
    localparam int unsigned HASH_BITS      = 64;
    localparam int unsigned BYTE_BITS      = 8;
    localparam int unsigned COUNT_BITS_DEF = 32;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SALT_PREFIX = 1'b0,
        REG_SALT_SUFFIX = 1'b1
    } cfg_reg_t;

    // Control group handed from the handshake logic to the hash core.
    typedef struct packed {
        logic fire;
        logic last;
        logic empty;
    } step_ctl_t;

    // Multiply by 1000003 modulo 2^64 as a sum of shifted copies.
    // 1000003 = 2^19 + 2^18 + 2^17 + 2^16 + 2^14 + 2^9 + 2^6 + 2^1 + 2^0.
    function automatic logic [HASH_BITS-1:0] mul_hash(input logic [HASH_BITS-1:0] x);
        logic [HASH_BITS-1:0] low_sum;
        logic [HASH_BITS-1:0] high_sum;
        low_sum  = x + (x << 1) + (x << 6) + (x << 9);
        high_sum = (x << 14) + (x << 16) + (x << 17) + (x << 18) + (x << 19);
        return low_sum + high_sum;
    endfunction

endpackage

@@ rtl/ssh_core.sv @@
// Hash core: running accumulator, byte counter and the per-byte update.
`include "salted_string_hash_unit_macros.svh"

module ssh_core
    import ssh_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  step_ctl_t             ctl,
    input  logic [BYTE_BITS-1:0]  text_byte,
    input  logic [HASH_BITS-1:0]  salt_prefix,
    input  logic [HASH_BITS-1:0]  salt_suffix,
    output logic [HASH_BITS-1:0]  hash_value
);

    logic [HASH_BITS-1:0]  acc_reg;
    logic [HASH_BITS-1:0]  acc_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [BYTE_BITS-1:0]  single_reg;
    logic [BYTE_BITS-1:0]  single_next;

    logic                  first;
    logic [HASH_BITS-1:0]  acc_base;
    logic [HASH_BITS-1:0]  acc_step;
    logic [COUNT_BITS-1:0] count_step;
    logic [BYTE_BITS-1:0]  single_step;

    // One byte of the hash: seed on the first byte, then multiply and fold in.
    always_comb
    begin
        first       = (count_reg == '0);
        acc_base    = first ? (salt_prefix ^ (HASH_BITS'(text_byte) << FIRST_SHIFT))
                            : acc_reg;
        acc_step    = mul_hash(acc_base) ^ HASH_BITS'(text_byte);
        count_step  = (count_reg != '1) ? count_reg + COUNT_BITS'(1) : count_reg;
        single_step = first ? text_byte : single_reg;
    end

    // Result of a finished string; a one-byte string hashes to the byte itself.
    always_comb
    begin
        if (ctl.empty)
        begin
            hash_value = '0;
        end
        else if (count_step == COUNT_BITS'(1))
        begin
            hash_value = HASH_BITS'(single_step);
        end
        else
        begin
            hash_value = acc_step ^ HASH_BITS'(count_step) ^ salt_suffix;
        end
    end

    // Next state: a string end or an empty mark returns to idle values.
    always_comb
    begin
        acc_next    = acc_reg;
        count_next  = count_reg;
        single_next = single_reg;
        if (ctl.fire)
        begin
            if (ctl.empty || ctl.last)
            begin
                acc_next    = '0;
                count_next  = '0;
                single_next = '0;
            end
            else
            begin
                acc_next    = acc_step;
                count_next  = count_step;
                single_next = single_step;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            count_reg  <= '0;
            single_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            count_reg  <= count_next;
            single_reg <= single_next;
        end
    end

    // A string end leaves the counter at zero for the next string.
    `SSH_ASSERT_NXT(a_end_clears_count, clk, rst_n, ctl.fire && (ctl.last || ctl.empty), count_reg == '0, "count not cleared at string end")
    // A byte inside a string leaves a nonzero count.
    `SSH_ASSERT_NXT(a_mid_byte_counts, clk, rst_n, ctl.fire && !ctl.last && !ctl.empty, count_reg != '0, "count zero inside a string")
    // An empty string hashes to zero.
    `SSH_ASSERT_IMP(a_empty_zero, clk, rst_n, ctl.fire && ctl.empty, hash_value == '0, "empty string hash not zero")

endmodule

@@ rtl/salted_string_hash_unit.sv @@
// Top level of the salted string hash unit: stream ports, salts, input and result registers.
//
//   channel   direction  transfer content
//   s_axis    in         one string byte, last mark, empty mark
//   m_axis    out        64-bit hash of a finished string
//   cfg       in         salt register write (index, data)
//
// One byte per cycle unless a string end waits on a stalled m_axis: each transfer is
// registered in the input register, then the hash core updates the accumulator (one
// constant multiply and XOR) and, at a string end, loads the result register.
// Reset (rst_n, asynchronous) clears the salts, the hash state and both valid flags.
// A stall on m_axis holds the result; the input register still drains when its item
// yields no result, and s_axis_tready drops only when both registers are full.
`include "salted_string_hash_unit_macros.svh"

module salted_string_hash_unit
    import ssh_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_BITS-1:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,   // final_byte
    input  logic                  s_axis_tuser,   // [0] empty_string

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [HASH_BITS-1:0]  m_axis_tdata,   // [63:0] hash_value

    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [HASH_BITS-1:0]  cfg_data
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_last_reg;
    logic                 in_empty_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [HASH_BITS-1:0] out_hash_reg;

    logic [HASH_BITS-1:0] prefix_reg;
    logic [HASH_BITS-1:0] suffix_reg;

    logic                 in_xfer;
    logic                 advance;
    logic                 produce;
    step_ctl_t            ctl;
    logic [HASH_BITS-1:0] core_hash;

    // Handshake: a byte without a result always steps; a string end steps when the
    // result register can take its result.
    always_comb
    begin
        advance        = in_valid_reg && (!(in_last_reg || in_empty_reg) ||
                                          !out_valid_reg || m_axis_tready);
        produce        = advance && (in_last_reg || in_empty_reg);
        s_axis_tready  = !in_valid_reg || advance;
        in_xfer        = s_axis_tvalid && s_axis_tready;
        in_valid_next  = in_xfer || (in_valid_reg && !advance);
        out_valid_next = produce || (out_valid_reg && !m_axis_tready);
        ctl.fire       = advance;
        ctl.last       = in_last_reg;
        ctl.empty      = in_empty_reg;
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
        if (produce)
        begin
            out_hash_reg <= core_hash;
        end
    end

    // Salt registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            suffix_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SALT_PREFIX: prefix_reg <= cfg_data;
                REG_SALT_SUFFIX: suffix_reg <= cfg_data;
                default:         prefix_reg <= prefix_reg;
            endcase
        end
    end

    ssh_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .text_byte   (in_byte_reg),
        .salt_prefix (prefix_reg),
        .salt_suffix (suffix_reg),
        .hash_value  (core_hash)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_hash_reg;

    // A step that ends a string always shows a result next cycle.
    `SSH_ASSERT_NXT(a_end_gives_result, clk, rst_n, produce, out_valid_reg, "string end without result")
    // The input side stalls only when both registers are full and the output is stalled.
    `SSH_ASSERT_IMP(a_stall_cause, clk, rst_n, !s_axis_tready, in_valid_reg && out_valid_reg && !m_axis_tready, "input stalled without cause")
    // An empty-string item yields a zero hash.
    `SSH_ASSERT_NXT(a_empty_result, clk, rst_n, advance && in_empty_reg, out_hash_reg == '0, "empty string result not zero")

endmodule

@@ tb/sv/salted_string_hash_unit_tb.sv @@
// Self-checking testbench for the salted string hash unit with its own hash predictor.
`timescale 1ns / 100ps

module salted_string_hash_unit_tb;
    import ssh_pkg::*;

    localparam int unsigned COUNT_BITS    = COUNT_BITS_DEF;
    localparam int unsigned MAX_CYCLES    = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 160;
    localparam int unsigned NUM_PHASES    = 8;

    // One row of the directed stimulus; known rows carry a hand-derived hash.
    typedef struct packed {
        logic [7:0]  text;
        logic        last_mark;
        logic        empty_mark;
        logic        known;
        logic [63:0] hash;
    } directed_row_t;

    localparam int unsigned NUM_DIRECTED = 16;

    // Directed rows, run with the salts at their reset value of zero.
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // Empty string with the other fields set: they are ignored.
        '{8'hFF, 1'b1, 1'b1, 1'b1, 64'h0},
        // One-byte strings hash to the byte itself.
        '{8'h00, 1'b1, 1'b0, 1'b1, 64'h00},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 64'hFF},
        '{8'hA5, 1'b1, 1'b0, 1'b1, 64'hA5},
        // Three-byte string.
        '{8'h61, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h62, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h63, 1'b1, 1'b0, 1'b0, 64'h0},
        // Two-byte strings at both byte extremes.
        '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
        // Empty mark in the middle of a string drops it and yields zero.
        '{8'h12, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h34, 1'b0, 1'b0, 1'b0, 64'h0},
        '{8'h56, 1'b1, 1'b1, 1'b1, 64'h0},
        // The next byte starts a fresh string.
        '{8'h80, 1'b1, 1'b0, 1'b1, 64'h80},
        // Empty string with the last mark low.
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_BITS-1:0]  s_axis_tdata;   // [7:0] text_byte
    logic                  s_axis_tlast;   // final_byte
    logic                  s_axis_tuser;   // [0] empty_string
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [HASH_BITS-1:0]  m_axis_tdata;   // [63:0] hash_value
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [HASH_BITS-1:0]  cfg_data;

    // Predictor state: salts, running hash, string length and first byte.
    logic [63:0]           salt_head;
    logic [63:0]           salt_tail;
    logic [63:0]           run_hash;
    logic [COUNT_BITS-1:0] run_len;
    logic [7:0]            lead_text;

    logic [63:0]  pending_hashes [$];
    int unsigned  fail_count;
    int unsigned  items_sent;
    int unsigned  cycle_count;
    int unsigned  src_calm;
    int unsigned  sink_calm;

    salted_string_hash_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Random wait before the next transfer, with calm stretches of no waiting.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(1, 15);
    endfunction

    function automatic void clear_run();
        run_hash  = '0;
        run_len   = '0;
        lead_text = '0;
    endfunction

    // Fold one byte into the running hash; returns 1 when the transfer finishes a string.
    function automatic bit fold_hash_byte(input logic [7:0] text, input logic last_mark,
                                          input logic empty_mark, output logic [63:0] hash);
        hash = '0;
        if (empty_mark)
        begin
            clear_run();
            return 1'b1;
        end
        if (run_len == 0)
        begin
            run_hash  = salt_head ^ (64'(text) << FIRST_SHIFT);
            lead_text = text;
        end
        run_hash = (run_hash * 64'(HASH_MULT)) ^ 64'(text);
        if (run_len != '1)
            run_len = run_len + 1'b1;
        if (!last_mark)
            return 1'b0;
        if (run_len == 1)
            hash = 64'(lead_text);
        else
            hash = run_hash ^ 64'(run_len) ^ salt_tail;
        clear_run();
        return 1'b1;
    endfunction

    // Byte values weighted toward the extremes.
    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Drive one input transfer and record its expected hash, if any.
    task automatic send_item(input logic [7:0] text, input logic last_mark,
                             input logic empty_mark, input logic known,
                             input logic [63:0] known_hash);
        int unsigned gap;
        logic [63:0] hash;
        gap = draw_wait(src_calm);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text;
        s_axis_tlast  <= last_mark;
        s_axis_tuser  <= empty_mark;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (fold_hash_byte(text, last_mark, empty_mark, hash))
            pending_hashes.push_back(known ? known_hash : hash);
        items_sent++;
        @(negedge clk);
    endtask

    // Send a complete string of the given length with random content.
    task automatic send_string(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(pick_text(), k == len - 1, 1'b0, 1'b0, '0);
    endtask

    // Mostly well-formed strings; the rest are empty strings and aborted strings.
    task automatic run_strings(input int unsigned count);
        int unsigned start;
        int unsigned kind;
        int unsigned len;
        start = items_sent;
        while (items_sent - start < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
            begin
                send_item(pick_text(), 1'($urandom), 1'b1, 1'b0, '0);
            end
            else if (kind < 14)
            begin
                len = $urandom_range(1, 5);
                repeat (len) send_item(pick_text(), 1'b0, 1'b0, 1'b0, '0);
                send_item(pick_text(), 1'($urandom), 1'b1, 1'b0, '0);
            end
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 20)
                    len = 1;
                else if (kind < 85)
                    len = $urandom_range(2, 10);
                else
                    len = $urandom_range(11, 48);
                send_string(len);
            end
        end
    endtask

    // Let every expected hash arrive, then let the pipeline drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both salt registers on consecutive cycles.
    task automatic set_salts(input logic [63:0] head, input logic [63:0] tail);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SALT_PREFIX;
        cfg_data  <= head;
        @(negedge clk);
        cfg_index <= REG_SALT_SUFFIX;
        cfg_data  <= tail;
        @(negedge clk);
        cfg_we    <= 1'b0;
        salt_head = head;
        salt_tail = tail;
    endtask

    // Stimulus: reset, directed rows, then random phases over several salt settings.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SALT_PREFIX;
        cfg_data      = '0;
        salt_head     = '0;
        salt_tail     = '0;
        fail_count    = 0;
        items_sent    = 0;
        src_calm      = 0;
        clear_run();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int unsigned r = 0; r < NUM_DIRECTED; r++)
            send_item(DIRECTED_ROWS[r].text, DIRECTED_ROWS[r].last_mark,
                      DIRECTED_ROWS[r].empty_mark, DIRECTED_ROWS[r].known,
                      DIRECTED_ROWS[r].hash);

        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0:       set_salts('1, '1);
                1:       set_salts('1, '0);
                2:       set_salts('0, '1);
                3:       set_salts('0, '0);
                default: set_salts({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            run_strings(PHASE_ITEMS);
        end

        settle();
        if (pending_hashes.size() != 0)
        begin
            $display("%0t: %0d expected hash values never arrived", $time,
                     pending_hashes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: random stalls before each transfer.
    initial
    begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        sink_calm     = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_wait(sink_calm);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest expected hash.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash_value, expected none, actual %h", $time,
                         m_axis_tdata);
                fail_count++;
            end
            else
            begin
                if (m_axis_tdata !== pending_hashes[0])
                begin
                    $display("%0t: hash_value mismatch, expected %h, actual %h", $time,
                             pending_hashes[0], m_axis_tdata);
                    fail_count++;
                end
                void'(pending_hashes.pop_front());
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= MAX_CYCLES)
            begin
                $display("%0t: run exceeded %0d cycles", $time, MAX_CYCLES);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
